### hw/rtl/m3inv_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies; imported by matrix3_inverse.
package m3inv_pkg;

   localparam int ELEM_WIDTH_DEF   = 16;
   localparam int RESULT_WIDTH_DEF = 32;
   localparam int THR_WIDTH        = 47;
   localparam int QUOT_SHIFT       = 28;
   localparam int CSR_DATA_WIDTH   = 64;
   localparam int CSR_ADDR_WIDTH   = 4;
   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(65536);

   // cofactor k = m[a]*m[b] - m[c]*m[d], listed as {a, b, c, d}
   localparam int COF_IDX [9][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

   // first-column elements used in the determinant expansion
   localparam int DET_IDX [3] = '{0, 3, 6};

   typedef enum logic {
      CSR_DET_THR = 1'b0
   } csr_idx_type;

endpackage

### hw/rtl/matrix3_inverse.sv
// Pipelined 3x3 matrix inverse by cofactors, Q4.12 in, Q16.16 out.
// Depends on m3inv_pkg.
//
// One matrix per transaction on req_*, one inverse per transaction on rsp_*,
// in order. The datapath is a fixed pipeline: input capture, 18 products,
// cofactors, determinant products, determinant sum, magnitudes and singular
// check, numerator build, then a restoring divider with one quotient bit per
// stage (RESULT_WIDTH stages, nine lanes side by side), a saturation stage
// and an output register with a skid entry. A new matrix is taken every
// cycle while the skid entry is empty. Throughput is one matrix per clock,
// set by the per-bit divider stages, which all advance together. req_tready
// drops only while the skid entry holds a result that the sink has not taken.
// det_zero_threshold (byte address 0, 47 bits used) sets the determinant
// magnitude, in 2^-36 units, at or below which the result is all zeros with
// rsp_tuser set. Write it only while no transaction is in flight.
module matrix3_inverse
   import m3inv_pkg::*;
#(
   parameter int ELEM_WIDTH   = ELEM_WIDTH_DEF,
   parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // fields from bit 0 up: e0, e1, ... e8, each ELEM_WIDTH signed
   input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]          req_tdata,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // fields from bit 0 up: r0, r1, ... r8, each RESULT_WIDTH signed
   output logic [((9*RESULT_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // fields from bit 0 up: singular
   output logic                                       rsp_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]                  csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]                  csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]                  csr_prdata,
   output logic                                       csr_pready
);

   localparam int E    = ELEM_WIDTH;
   localparam int R    = RESULT_WIDTH;
   localparam int PW   = 2*E;          // element product
   localparam int CW   = 2*E + 1;      // cofactor
   localparam int DPW  = 3*E + 1;      // element times cofactor
   localparam int DW   = 3*E + 3;      // determinant
   localparam int NW   = ((CW + QUOT_SHIFT) > DW ? CW + QUOT_SHIFT : DW) + 1;
   localparam int XW   = NW + R;       // divisor shifted by up to R
   localparam int CMPW = DW > THR_WIDTH ? DW : THR_WIDTH;
   localparam int ODW  = ((9*R+7)/8)*8;

   // ---------------- configuration ----------------
   logic [THR_WIDTH-1:0] thr_ff;
   csr_idx_type          csr_idx;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_idx_type'(csr_paddr[CSR_ADDR_WIDTH-1]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_WIDTH-2:0] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_DET_THR: thr_ff <= csr_pwdata[THR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_WIDTH-2:0] == '0) begin
         unique case (csr_idx)
            CSR_DET_THR: csr_prdata = CSR_DATA_WIDTH'(thr_ff);
            default: csr_prdata = '0;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // All stages move together unless the skid entry is occupied.
   logic adv;
   logic skid_v_ff;
   logic out_v_ff;
   logic rsp_take;

   assign adv        = !skid_v_ff;
   assign req_tready = adv;
   assign rsp_take   = out_v_ff && rsp_tready;

   // stage 1: input capture
   logic                s1_v_ff;
   logic signed [E-1:0] m_ff [9];
   // stage 2: products
   logic                s2_v_ff;
   logic signed [PW-1:0] pr_ff [18];
   logic signed [E-1:0]  mc2_ff [3];
   // stage 3: cofactors
   logic                 s3_v_ff;
   logic signed [CW-1:0] cof3_ff [9];
   logic signed [E-1:0]  mc3_ff [3];
   // stage 4: determinant terms
   logic                  s4_v_ff;
   logic signed [DPW-1:0] dp_ff [3];
   logic signed [CW-1:0]  cof4_ff [9];
   // stage 5: determinant
   logic                 s5_v_ff;
   logic signed [DW-1:0] det_ff;
   logic signed [CW-1:0] cof5_ff [9];
   // stage 6: magnitudes, sign, singular
   logic          s6_v_ff;
   logic [DW-1:0] dmag6_ff;
   logic [CW-1:0] cmag6_ff [9];
   logic          neg6_ff [9];
   logic          sing6_ff;
   // divider stages; index 0 holds the numerator stage
   logic          dv_ff   [R+1];
   logic [NW-1:0] drem_ff [R+1][9];
   logic [R-1:0]  dq_ff   [R+1][9];
   logic          dovf_ff [R+1][9];
   logic          dneg_ff [R+1][9];
   logic [DW-1:0] dd_ff   [R+1];
   logic          dsing_ff [R+1];
   // saturation stage
   logic           fv_ff;
   logic [9*R-1:0] fres_ff;
   logic           fsing_ff;
   // output register and skid entry
   logic [9*R-1:0] out_data_ff;
   logic           out_sing_ff;
   logic [9*R-1:0] skid_data_ff;
   logic           skid_sing_ff;

   // next values
   logic signed [PW-1:0] pr_in [18];
   logic signed [CW-1:0] cof_in [9];
   logic signed [DPW-1:0] dp_in [3];
   logic signed [DW-1:0] det_in;
   logic [DW-1:0]  dmag_in;
   logic [CW-1:0]  cmag_in [9];
   logic [NW-1:0]  num_in [9];
   logic [NW-1:0]  drem_in [R][9];
   logic [R-1:0]   dq_in [R][9];
   logic           dovf_in [R][9];
   logic [9*R-1:0] fres_in;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         pr_in[2*k]   = m_ff[COF_IDX[k][0]] * m_ff[COF_IDX[k][1]];
         pr_in[2*k+1] = m_ff[COF_IDX[k][2]] * m_ff[COF_IDX[k][3]];
         cof_in[k]    = CW'(pr_ff[2*k]) - CW'(pr_ff[2*k+1]);
         cmag_in[k]   = cof5_ff[k][CW-1] ? CW'(-cof5_ff[k]) : CW'(cof5_ff[k]);
         num_in[k]    = (NW'(cmag6_ff[k]) << QUOT_SHIFT) + NW'(dmag6_ff >> 1);
      end
      for (int i = 0; i < 3; i++) begin
         dp_in[i] = mc3_ff[i] * cof3_ff[i];
      end
      det_in  = DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
      dmag_in = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   end

   // one restoring step per stage: quotient bit R-1-j at stage j
   always_comb begin
      logic [XW-1:0] sub;
      logic          ge;
      for (int j = 0; j < R; j++) begin
         for (int k = 0; k < 9; k++) begin
            sub = XW'(dd_ff[j]) << (R-1-j);
            ge  = XW'(drem_ff[j][k]) >= sub;
            drem_in[j][k] = ge ? drem_ff[j][k] - sub[NW-1:0] : drem_ff[j][k];
            dq_in[j][k]   = dq_ff[j][k] | (R'(ge) << (R-1-j));
            if (j == 0) begin
               // quotient would need more than R bits
               dovf_in[j][k] = XW'(drem_ff[j][k]) >= (XW'(dd_ff[j]) << R);
            end else begin
               dovf_in[j][k] = dovf_ff[j][k];
            end
         end
      end
   end

   // rounding already in the numerator; clamp to R signed bits
   always_comb begin
      logic [R-1:0] q;
      logic [R-1:0] lim;
      logic [R-1:0] r;
      lim = R'(1) << (R-1);
      for (int k = 0; k < 9; k++) begin
         q = dq_ff[R][k];
         if (dsing_ff[R]) begin
            r = '0;
         end else if (dovf_ff[R][k]) begin
            r = dneg_ff[R][k] ? lim : lim - R'(1);
         end else if (q == '0) begin
            r = '0;
         end else if (dneg_ff[R][k]) begin
            r = (q > lim) ? lim : (~q + R'(1));
         end else begin
            r = (q > lim - R'(1)) ? lim - R'(1) : q;
         end
         fres_in[k*R +: R] = r;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         fv_ff   <= 1'b0;
         for (int j = 0; j <= R; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         s1_v_ff  <= req_tvalid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= s5_v_ff;
         dv_ff[0] <= s6_v_ff;
         for (int j = 0; j < R; j++) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         fv_ff <= dv_ff[R];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            m_ff[k]    <= req_tdata[k*E +: E];
            cof3_ff[k] <= cof_in[k];
            cof4_ff[k] <= cof3_ff[k];
            cof5_ff[k] <= cof4_ff[k];
            cmag6_ff[k] <= cmag_in[k];
            neg6_ff[k]  <= cof5_ff[k][CW-1] ^ det_ff[DW-1];
            drem_ff[0][k] <= num_in[k];
            dq_ff[0][k]   <= '0;
            dovf_ff[0][k] <= 1'b0;
            dneg_ff[0][k] <= neg6_ff[k];
         end
         for (int p = 0; p < 18; p++) begin
            pr_ff[p] <= pr_in[p];
         end
         for (int i = 0; i < 3; i++) begin
            mc2_ff[i] <= m_ff[DET_IDX[i]];
            mc3_ff[i] <= mc2_ff[i];
            dp_ff[i]  <= dp_in[i];
         end
         det_ff   <= det_in;
         dmag6_ff <= dmag_in;
         sing6_ff <= CMPW'(dmag_in) <= CMPW'(thr_ff);
         dd_ff[0]    <= dmag6_ff;
         dsing_ff[0] <= sing6_ff;
         for (int j = 0; j < R; j++) begin
            for (int k = 0; k < 9; k++) begin
               drem_ff[j+1][k] <= drem_in[j][k];
               dq_ff[j+1][k]   <= dq_in[j][k];
               dovf_ff[j+1][k] <= dovf_in[j][k];
               dneg_ff[j+1][k] <= dneg_ff[j][k];
            end
            dd_ff[j+1]    <= dd_ff[j];
            dsing_ff[j+1] <= dsing_ff[j];
         end
         fres_ff  <= fres_in;
         fsing_ff <= dsing_ff[R];
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (skid_v_ff) begin
            if (rsp_take) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end
         end else if (fv_ff) begin
            if (!out_v_ff || rsp_take) begin
               out_v_ff <= 1'b1;
            end else begin
               skid_v_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_take) begin
            out_data_ff <= skid_data_ff;
            out_sing_ff <= skid_sing_ff;
         end
      end else if (fv_ff) begin
         if (!out_v_ff || rsp_take) begin
            out_data_ff <= fres_ff;
            out_sing_ff <= fsing_ff;
         end else begin
            skid_data_ff <= fres_ff;
            skid_sing_ff <= fsing_ff;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = ODW'(out_data_ff);
   assign rsp_tuser  = out_sing_ff;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry occupied while output register empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid entry filled without a stalled output");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_sing_ff |-> out_data_ff == '0)
      else $error("singular result carries nonzero data");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_ff[R]) && $stable(fv_ff))
      else $error("pipeline moved while frozen");
`endif

endmodule

### verif/matrix3_inverse_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 matrix inverse block (matrix3_inverse).
// Depends on m3inv_pkg and the block's RTL; holds its own predictor and scoreboard.

// Scoreboard: predicts the inverse of each accepted matrix, checks results in order.
class inverse_scoreboard;
   typedef struct packed {
      logic [8:0][31:0] elem;
      logic             singular;
   } inverse_type;

   inverse_type     pending_q[$];
   logic [46:0]     det_thr;
   int              mismatches;
   int              checked;
   int              singular_seen;
   int              saturated_seen;

   function new();
      det_thr = 47'd65536;
      mismatches = 0;
      checked = 0;
      singular_seen = 0;
      saturated_seen = 0;
   endfunction

   task report(string what);
      mismatches++;
      $display("MISMATCH #%0d at %0t: %s", mismatches, $realtime, what);
   endtask

   // C * 2^28 / D, round half away from zero, saturate to Q16.16
   function logic [31:0] scaled_quotient(longint signed cof, longint signed det);
      logic [63:0] cmag;
      logic [63:0] dmag;
      logic [63:0] quo;
      bit          neg;
      cmag = cof < 0 ? -cof : cof;
      dmag = det < 0 ? -det : det;
      neg = (cof < 0) != (det < 0);
      quo = ((cmag << 28) + (dmag >> 1)) / dmag;
      if (quo == 0) return 32'd0;
      if (neg) begin
         if (quo > 64'h8000_0000) quo = 64'h8000_0000;
         return 32'(-quo);
      end
      if (quo > 64'h7fff_ffff) quo = 64'h7fff_ffff;
      return quo[31:0];
   endfunction

   function void note_matrix(logic [143:0] data);
      longint signed m[9];
      longint signed cof[9];
      longint signed det;
      logic [63:0]   dmag;
      inverse_type   exp_inv;
      for (int k = 0; k < 9; k++) m[k] = longint'($signed(data[16*k +: 16]));
      cof[0] = m[4]*m[8] - m[5]*m[7];
      cof[1] = m[2]*m[7] - m[1]*m[8];
      cof[2] = m[1]*m[5] - m[2]*m[4];
      cof[3] = m[5]*m[6] - m[3]*m[8];
      cof[4] = m[0]*m[8] - m[2]*m[6];
      cof[5] = m[2]*m[3] - m[0]*m[5];
      cof[6] = m[3]*m[7] - m[4]*m[6];
      cof[7] = m[1]*m[6] - m[0]*m[7];
      cof[8] = m[0]*m[4] - m[1]*m[3];
      det = m[0]*cof[0] + m[3]*cof[1] + m[6]*cof[2];
      dmag = det < 0 ? -det : det;
      exp_inv = '0;
      if (dmag <= {17'd0, det_thr}) begin
         exp_inv.singular = 1'b1;
      end else begin
         for (int k = 0; k < 9; k++) exp_inv.elem[k] = scaled_quotient(cof[k], det);
      end
      pending_q.push_back(exp_inv);
   endfunction

   task check_result(logic [287:0] data, logic flag);
      inverse_type exp_inv;
      checked++;
      if (pending_q.size() == 0) begin
         report("result with no matrix outstanding");
         return;
      end
      exp_inv = pending_q.pop_front();
      if (flag !== exp_inv.singular)
         report($sformatf("singular got %b exp %b", flag, exp_inv.singular));
      for (int k = 0; k < 9; k++)
         if (data[32*k +: 32] !== exp_inv.elem[k])
            report($sformatf("r%0d got %h exp %h", k, data[32*k +: 32], exp_inv.elem[k]));
      if (exp_inv.singular) singular_seen++;
      for (int k = 0; k < 9; k++)
         if (exp_inv.elem[k] == 32'h7fff_ffff || exp_inv.elem[k] == 32'h8000_0000) begin
            saturated_seen++;
            break;
         end
   endtask
endclass

module matrix3_inverse_tb;
   import m3inv_pkg::*;

   localparam int LATENCY       = 40;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 1600;

   logic          clock;
   logic          reset;
   logic [143:0]  req_tdata;   // e0..e8 from bit 0 up, 16-bit signed Q4.12 each
   logic          req_tvalid;
   logic          req_tready;
   logic [287:0]  rsp_tdata;   // r0..r8 from bit 0 up, 32-bit signed Q16.16 each
   logic          rsp_tuser;   // singular
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic          csr_pready;

   inverse_scoreboard sb;
   int            idle_cycles;
   int            sent_count;
   int            stall_mode;

   matrix3_inverse dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: accept and check, stall per current pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(3, 0) != 0);
            2: rsp_tready <= ($urandom_range(3, 0) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", sb.pending_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // register write: setup phase then access phase
   task automatic write_threshold(logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(8 * CSR_DET_THR);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.det_thr = value[46:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // one matrix transaction; valid stays high across back-to-back sends
   task automatic send_matrix(logic [143:0] data);
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_matrix(data);
      sent_count++;
   endtask

   task automatic gap(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // wait out every outstanding result, then the pipeline depth
   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(7, 0))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'(($urandom_range(1) ? 1 : -1) * 4096);   // +/-1.0
         4: return 16'($signed($urandom_range(255, 0)) - 128);  // tiny values
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [143:0] rand_matrix();
      logic [143:0] mat;
      int           pick;
      for (int k = 0; k < 9; k++) mat[16*k +: 16] = rand_elem();
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
         // linearly dependent: row 2 copies row 0
         mat[96 +: 48] = mat[0 +: 48];
      end else if (pick == 1) begin
         // diagonal, mostly well conditioned
         mat = '0;
         mat[0 +: 16]   = rand_elem();
         mat[64 +: 16]  = rand_elem();
         mat[128 +: 16] = rand_elem();
      end else if (pick == 2) begin
         for (int k = 0; k < 9; k++) mat[16*k +: 16] = 16'($urandom);
      end
      return mat;
   endfunction

   function automatic logic [143:0] diag(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      return {a, 16'h0, 16'h0, 16'h0, b, 16'h0, 16'h0, 16'h0, c};
   endfunction

   initial begin
      logic [143:0] mat;
      int           burst;
      sb = new();
      sent_count  = 0;
      stall_mode  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, extremes, singular, saturation
      send_matrix(diag(16'h1000, 16'h1000, 16'h1000));
      send_matrix(diag(16'h7fff, 16'h7fff, 16'h7fff));
      send_matrix(diag(16'h8000, 16'h8000, 16'h8000));
      send_matrix(diag(16'h8000, 16'h7fff, 16'h8000));
      send_matrix(diag(16'h0001, 16'h0001, 16'h0001));   // tiny det, singular
      send_matrix(diag(16'h0001, 16'h7fff, 16'h7fff));   // huge inverse entry
      send_matrix(diag(16'hffff, 16'h7fff, 16'h7fff));   // negative huge inverse entry
      send_matrix('0);
      send_matrix({9{16'h7fff}});
      send_matrix({9{16'h8000}});
      send_matrix({9{16'hffff}});
      send_matrix({16'h1000, 16'h0800, 16'h0400, 16'h0200, 16'h1000,
                   16'h0100, 16'h0080, 16'h0040, 16'h1000});
      send_matrix({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                   16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
      send_matrix({16'h8000, 16'h7fff, 16'h0001, 16'h7fff, 16'h8000,
                   16'h0002, 16'h0001, 16'h0003, 16'h7fff});
      drain();

      // zero threshold: only an exact zero determinant counts singular
      write_threshold(64'd0);
      send_matrix('0);
      send_matrix(diag(16'h0001, 16'h0001, 16'h0001));
      send_matrix(diag(16'h0001, 16'h0001, 16'hffff));
      drain();
      // largest threshold, with bits above 47 set
      write_threshold(64'hffff_ffff_ffff_ffff);
      send_matrix(diag(16'h1000, 16'h1000, 16'h1000));
      send_matrix(diag(16'h7fff, 16'h7fff, 16'h7fff));
      drain();

      // random phases, each with its own threshold and receiver stall pattern
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: write_threshold(64'd65536);
            1: write_threshold(64'd0);
            2: write_threshold(64'($urandom) << $urandom_range(16, 0));
            default: write_threshold(64'h0000_7fff_ffff_ffff);
         endcase
         stall_mode = phase % 4;
         while (sent_count < 25 + (phase + 1) * RANDOM_ITEMS / 8) begin
            burst = $urandom_range(40, 1);
            repeat (burst) send_matrix(rand_matrix());
            if ($urandom_range(3, 0) == 0) gap($urandom_range(6, 1));
            if ($urandom_range(30, 0) == 0) drain();   // let the pipe empty
         end
         drain();
      end

      $display("Covered %0d matrices, %0d results, %0d singular, %0d saturated.",
               sent_count, sb.checked, sb.singular_seen, sb.saturated_seen);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d left outstanding",
                  sb.mismatches, sb.pending_q.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
